// File: design/rmc_pkg.sv
// Package for the RMC time and date parser: phase codes, ASCII constants,
// the capture and result structs, and the calendar helper.
// No dependencies.
package rmc_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
   localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'

   localparam int HEADER_LEN  = 5;  // "GPRMC" after the dollar
   localparam int TIME_LAST   = 9;  // hhmmss . mmm
   localparam int DATE_COMMA  = 9;  // date field follows the ninth comma
   localparam int DATE_DIGITS = 6;  // ddmmyy

   localparam logic [4:0] OFFSET_RESET = 5'd8;
   localparam logic [4:0] OFFSET_MAX   = 5'd23;

   typedef enum logic [6:0] {
      PH_HUNT   = 7'b0000001,
      PH_HEADER = 7'b0000010,
      PH_COMMA1 = 7'b0000100,
      PH_TIME   = 7'b0001000,
      PH_COMMA2 = 7'b0010000,
      PH_SKIP   = 7'b0100000,
      PH_DATE   = 7'b1000000
   } rmc_phase_type;

   // Raw UTC fields as captured from one sentence
   typedef struct packed {
      logic [6:0] utc_hour;
      logic [6:0] utc_minute;
      logic [6:0] utc_second;
      logic [9:0] utc_millis;
      logic [6:0] utc_day;
      logic [6:0] utc_month;
      logic [6:0] utc_year;
      logic       bad_digit;
   } rmc_capture_type;

   typedef struct packed {
      logic       valid_res;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] millisecond;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } rmc_result_type;

   // Days in a month; leap year whenever the two-digit year is a multiple of 4
   function automatic logic [4:0] month_length(input logic [6:0] month,
                                               input logic [6:0] year);
      logic [4:0] len;
      if (month == 7'd2) begin
         len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      end else if (month == 7'd4 || month == 7'd6 || month == 7'd9 || month == 7'd11) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

// File: design/rmc_parser.sv
// Byte-wise sentence parser: header hunt, comma counting and digit capture.
// Depends on rmc_pkg.
module rmc_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output logic                     done,
   output rmc_pkg::rmc_capture_type cap
);
   import rmc_pkg::*;

   rmc_phase_type   phase_ff, phase_in;
   logic [2:0]      header_index_ff, header_index_in;
   logic [3:0]      field_commas_ff, field_commas_in;
   logic [3:0]      digit_index_ff, digit_index_in;
   rmc_capture_type vals_ff, vals_in;

   logic       is_digit;
   logic [3:0] dval;
   logic       restart;
   logic [7:0] hdr_char;

   function automatic logic [6:0] acc7(input logic [6:0] acc, input logic [3:0] d);
      return 7'({acc, 3'b000} + {acc, 1'b0} + {3'b000, d});
   endfunction

   function automatic logic [9:0] acc10(input logic [9:0] acc, input logic [3:0] d);
      return 10'({acc, 3'b000} + {acc, 1'b0} + {6'd0, d});
   endfunction

   always_comb begin
      case (header_index_ff)
         3'd0:    hdr_char = 8'h47;  // G
         3'd1:    hdr_char = 8'h50;  // P
         3'd2:    hdr_char = 8'h52;  // R
         3'd3:    hdr_char = 8'h4D;  // M
         3'd4:    hdr_char = 8'h43;  // C
         default: hdr_char = 8'h00;
      endcase
   end

   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign dval     = is_digit ? 4'(rx_byte - CHAR_ZERO) : 4'd0;

   always_comb begin
      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      field_commas_in = field_commas_ff;
      digit_index_in  = digit_index_ff;
      vals_in         = vals_ff;
      restart         = 1'b0;
      done            = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            if (32'(header_index_ff) < HEADER_LEN && rx_byte == hdr_char) begin
               header_index_in = header_index_ff + 3'd1;
               if (32'(header_index_in) == HEADER_LEN) begin
                  phase_in = PH_COMMA1;
               end
            end else begin
               restart = 1'b1;
            end
         end
         PH_COMMA1: begin
            if (rx_byte == CHAR_COMMA) begin
               field_commas_in = 4'd1;
               digit_index_in  = 4'd0;
               phase_in        = PH_TIME;
            end else begin
               restart = 1'b1;
            end
         end
         PH_TIME: begin
            // Position six is the decimal point: skipped, not checked
            if (digit_index_ff != 4'd6 && !is_digit) begin
               vals_in.bad_digit = 1'b1;
            end
            case (digit_index_ff)
               4'd0, 4'd1: vals_in.utc_hour   = acc7(vals_ff.utc_hour, dval);
               4'd2, 4'd3: vals_in.utc_minute = acc7(vals_ff.utc_minute, dval);
               4'd4, 4'd5: vals_in.utc_second = acc7(vals_ff.utc_second, dval);
               4'd6:       vals_in.utc_millis = vals_ff.utc_millis;
               default:    vals_in.utc_millis = acc10(vals_ff.utc_millis, dval);
            endcase
            digit_index_in = digit_index_ff + 4'd1;
            if (32'(digit_index_in) > TIME_LAST) begin
               digit_index_in = 4'd0;
               phase_in       = PH_COMMA2;
            end
         end
         PH_COMMA2: begin
            if (rx_byte == CHAR_COMMA) begin
               field_commas_in = 4'd2;
               phase_in        = PH_SKIP;
            end else begin
               restart = 1'b1;
            end
         end
         PH_SKIP: begin
            if (rx_byte == CHAR_COMMA) begin
               field_commas_in = field_commas_ff + 4'd1;
            end
            if (32'(field_commas_in) >= DATE_COMMA) begin
               digit_index_in = 4'd0;
               phase_in       = PH_DATE;
            end
         end
         PH_DATE: begin
            if (!is_digit) begin
               vals_in.bad_digit = 1'b1;
            end
            case (digit_index_ff)
               4'd0, 4'd1: vals_in.utc_day   = acc7(vals_ff.utc_day, dval);
               4'd2, 4'd3: vals_in.utc_month = acc7(vals_ff.utc_month, dval);
               default:    vals_in.utc_year  = acc7(vals_ff.utc_year, dval);
            endcase
            digit_index_in = digit_index_ff + 4'd1;
            if (32'(digit_index_in) >= DATE_DIGITS) begin
               done            = 1'b1;
               phase_in        = PH_HUNT;
               header_index_in = 3'd0;
               field_commas_in = 4'd0;
               digit_index_in  = 4'd0;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // Drop the sentence; a dollar opens a fresh header at once
      if (restart) begin
         header_index_in = 3'd0;
         field_commas_in = 4'd0;
         digit_index_in  = 4'd0;
         if (rx_byte == CHAR_DOLLAR) begin
            phase_in = PH_HEADER;
            vals_in  = '0;
         end else begin
            phase_in = PH_HUNT;
         end
      end
   end

   // Captured fields as they stand after this byte
   assign cap = vals_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_index_ff <= 3'd0;
         field_commas_ff <= 4'd0;
         digit_index_ff  <= 4'd0;
         vals_ff         <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         field_commas_ff <= field_commas_in;
         digit_index_ff  <= digit_index_in;
         vals_ff         <= vals_in;
      end
   end

endmodule

// File: design/rmc_convert.sv
// Range checks and UTC to local time conversion with calendar rollover.
// Depends on rmc_pkg.
module rmc_convert (
   input  rmc_pkg::rmc_capture_type cap,
   input  logic [4:0]               hour_offset,
   output rmc_pkg::rmc_result_type  res
);
   import rmc_pkg::*;

   logic       ok;
   logic [4:0] off;
   logic [6:0] h_sum;
   logic       wrap;
   logic [6:0] h_loc;
   logic [4:0] len;
   logic [6:0] d_loc, m_loc, y_loc;

   assign ok = !cap.bad_digit
             && cap.utc_year >= 7'd12 && cap.utc_year <= 7'd98
             && cap.utc_month >= 7'd1 && cap.utc_month <= 7'd12
             && cap.utc_day >= 7'd1 && cap.utc_day <= 7'd31
             && cap.utc_hour <= 7'd24 && cap.utc_minute <= 7'd60
             && cap.utc_second <= 7'd60;

   assign off   = (hour_offset > OFFSET_MAX) ? OFFSET_MAX : hour_offset;
   assign h_sum = cap.utc_hour + {2'b00, off};
   assign wrap  = h_sum >= 7'd24;
   assign h_loc = wrap ? h_sum - 7'd24 : h_sum;
   assign len   = month_length(cap.utc_month, cap.utc_year);

   always_comb begin
      d_loc = cap.utc_day;
      m_loc = cap.utc_month;
      y_loc = cap.utc_year;
      if (wrap) begin
         if (cap.utc_day < {2'b00, len}) begin
            d_loc = cap.utc_day + 7'd1;
         end else if (cap.utc_day == {2'b00, len}) begin
            d_loc = 7'd1;
            if (cap.utc_month == 7'd12) begin
               m_loc = 7'd1;
               y_loc = cap.utc_year + 7'd1;
            end else begin
               m_loc = cap.utc_month + 7'd1;
            end
         end
         // a day already past the month's end stays as it is
      end
   end

   always_comb begin
      res = '0;
      if (ok) begin
         res.valid_res   = 1'b1;
         res.hour        = h_loc[4:0];
         res.minute      = cap.utc_minute[5:0];
         res.second      = cap.utc_second[5:0];
         res.millisecond = cap.utc_millis;
         res.day         = d_loc[4:0];
         res.month       = m_loc[3:0];
         res.year        = y_loc;
      end
   end

endmodule

// File: design/nmea_rmc_time_date_parser.sv
// Top level of the RMC time and date parser: input, capture and result stages.
// Depends on rmc_pkg, rmc_parser and rmc_convert.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_rx_byte (one ASCII byte)
//  rsp      out        rsp_valid/rsp_ready    rsp_valid_res, rsp_hour .. rsp_year
//  csr      in         csr_wr_en (no wait)    csr_wr_data (hour offset)
//
// One byte per cycle while no stage stalls. A byte is held in the input register while
// the parser state is updated from it; the final date byte's capture is then held in the
// capture register while the converter works, and the result is registered in the result
// register. Sync reset returns to hunting with offset 8. Each stage stalls only when the
// stage after it is full and not moving, so bytes keep being taken while one result
// waits on rsp_ready.
module nmea_rmc_time_date_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res,
   output logic [4:0] rsp_hour,
   output logic [5:0] rsp_minute,
   output logic [5:0] rsp_second,
   output logic [9:0] rsp_millisecond,
   output logic [4:0] rsp_day,
   output logic [3:0] rsp_month,
   output logic [6:0] rsp_year,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);
   import rmc_pkg::*;

   // Hour offset register
   logic [4:0] hour_offset_ff;

   // Input stage
   logic       in_v_ff;
   logic [7:0] byte_ff;

   // Capture stage
   logic            cap_v_ff;
   rmc_capture_type cap_ff;
   rmc_capture_type cap_in;
   logic            done;

   // Result stage
   logic           rsp_v_ff;
   rmc_result_type res_ff;
   rmc_result_type res_in;

   logic ready_c, ready_b, fire_a;

   // Per-stage ready, chained back from the consumer
   assign ready_c   = !rsp_v_ff || rsp_ready;
   assign ready_b   = !cap_v_ff || ready_c;
   assign fire_a    = in_v_ff && ready_b;
   assign req_ready = !in_v_ff || ready_b;

   rmc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (fire_a),
      .rx_byte (byte_ff),
      .done    (done),
      .cap     (cap_in)
   );

   rmc_convert u_convert (
      .cap         (cap_ff),
      .hour_offset (hour_offset_ff),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         hour_offset_ff <= csr_wr_data;
      end
   end

   // Control: valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         cap_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_v_ff <= req_valid;
         end
         if (ready_b) begin
            cap_v_ff <= fire_a && done;
         end
         if (ready_c) begin
            rsp_v_ff <= cap_v_ff;
         end
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
      if (fire_a && done) begin
         cap_ff <= cap_in;
      end
      if (cap_v_ff && ready_c) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_valid_res   = res_ff.valid_res;
   assign rsp_hour        = res_ff.hour;
   assign rsp_minute      = res_ff.minute;
   assign rsp_second      = res_ff.second;
   assign rsp_millisecond = res_ff.millisecond;
   assign rsp_day         = res_ff.day;
   assign rsp_month       = res_ff.month;
   assign rsp_year        = res_ff.year;

   // A valid result always carries a sane local calendar value
   a_valid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |->
         rsp_hour <= 5'd23 && rsp_month >= 4'd1 && rsp_month <= 4'd12
         && rsp_day >= 5'd1 && rsp_year <= 7'd99)
      else $error("valid result with out-of-range local fields");

   // Invalid sentences report zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_hour == 5'd0 && rsp_day == 5'd0 && rsp_month == 4'd0 && rsp_year == 7'd0)
      else $error("invalid result with non-zero fields");

   // A stalled capture must hold until the result stage takes it
   a_cap_hold: assert property (@(posedge clock) disable iff (reset)
      cap_v_ff && !ready_c |=> cap_v_ff && $stable(cap_ff))
      else $error("capture stage lost or changed while stalled");

   // A stalled byte must not advance the parser
   a_byte_hold: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !ready_b |=> in_v_ff && $stable(byte_ff))
      else $error("input byte lost or changed while stalled");

   // Bytes keep flowing while a result waits, as long as the capture stage is free
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !cap_v_ff |-> req_ready)
      else $error("input blocked by a waiting result alone");

endmodule
